[rtl/fixed_partition_fit_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define FPFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpfa assertion failed");

// Next-cycle implication, checked outside reset.
`define FPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpfa assertion failed");

`else

`define FPFA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/fpfa_pkg.sv]
package fpfa_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SIZE_BITS   = 16;

    // Fixed field widths of the channels and the configuration port
    localparam int REQ_TYPE_W = 2;
    localparam int ENTRY_IDX_W = 4;
    localparam int ENTRY_SIZE_W = 16;
    localparam int REQ_SIZE_W = 16;
    localparam int TAG_W = 8;
    localparam int PNUM_W = 5;
    localparam int POLICY_W = 2;
    localparam int PARTS_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    // Derived widths
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (SIZE_BITS > REQ_SIZE_W) ? SIZE_BITS : REQ_SIZE_W;
    localparam int LIM_W = (CNT_W > PARTS_W) ? CNT_W : PARTS_W;
    localparam int LDI_W = (CNT_W > ENTRY_IDX_W) ? CNT_W : ENTRY_IDX_W;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_LOAD     = 2'd0,
        REQ_FREE_ALL = 2'd1,
        REQ_ALLOC    = 2'd2
    } t_req_type;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } t_policy;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_POLICY   = 1'd0,
        CFG_PARTS_IN_USE = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic commit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_alloc;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/fpfa_if.sv]
interface fpfa_req_if import fpfa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REQ_TYPE_W-1:0]   req_type;
    logic [ENTRY_IDX_W-1:0]  entry_index;
    logic [ENTRY_SIZE_W-1:0] entry_size;
    logic [REQ_SIZE_W-1:0]   request_size;
    logic [TAG_W-1:0]        request_id;

    modport source (
        output valid, req_type, entry_index, entry_size, request_size, request_id,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, entry_size, request_size, request_id,
        output ready
    );
endinterface

interface fpfa_res_if import fpfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TAG_W-1:0]  tag_echo;
    logic              granted;
    logic [PNUM_W-1:0] partition_number;

    modport source (
        output valid, tag_echo, granted, partition_number,
        input  ready
    );
    modport sink (
        input  valid, tag_echo, granted, partition_number,
        output ready
    );
endinterface

[rtl/fpfa_ram.sv]
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fpfa_datapath.sv]
`include "fixed_partition_fit_allocator_assert.svh"

module fpfa_datapath import fpfa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [REQ_TYPE_W-1:0]   i_req_type,
    input  logic [ENTRY_IDX_W-1:0]  i_entry_index,
    input  logic [ENTRY_SIZE_W-1:0] i_entry_size,
    input  logic [REQ_SIZE_W-1:0]   i_request_size,
    input  logic [TAG_W-1:0]        i_request_id,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output logic [TAG_W-1:0]        o_tag_echo,
    output logic                    o_granted,
    output logic [PNUM_W-1:0]       o_partition_number
);

    // Latched item
    logic [REQ_TYPE_W-1:0]   r_type;
    logic [ENTRY_IDX_W-1:0]  r_eidx;
    logic [ENTRY_SIZE_W-1:0] r_esize;
    logic [REQ_SIZE_W-1:0]   r_rsize;
    logic [TAG_W-1:0]        r_tag;

    // Configuration
    logic [POLICY_W-1:0] r_policy;
    logic [PARTS_W-1:0]  r_parts;

    // Allocation flags and scan state
    logic [MAX_ENTRIES-1:0] r_busy;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_limit;
    logic                   r_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_found;
    logic [IDX_W-1:0]       r_pick_idx;
    logic [SIZE_BITS-1:0]   r_pick_size;

    // Output register
    logic              r_out_vld;
    logic [TAG_W-1:0]  r_out_tag;
    logic              r_out_grant;
    logic [PNUM_W-1:0] r_out_pnum;

    logic [LIM_W-1:0]     w_parts_ext;
    logic [CNT_W-1:0]     w_limit;
    logic                 w_load_ok;
    logic                 w_is_load;
    logic                 w_is_free;
    logic                 w_is_alloc;
    logic                 w_re;
    logic                 w_we;
    logic [SIZE_BITS-1:0] w_rdata;
    logic                 w_fits;
    logic                 w_take;
    logic                 w_grant;

    assign w_is_load  = (r_type == REQ_LOAD);
    assign w_is_free  = (r_type == REQ_FREE_ALL);
    assign w_is_alloc = (r_type == REQ_ALLOC);

    // Saturate the searched entry count at the table depth
    assign w_parts_ext = LIM_W'(r_parts);
    assign w_limit = (w_parts_ext > LIM_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(w_parts_ext);

    assign w_load_ok = (LDI_W'(r_eidx) < LDI_W'(MAX_ENTRIES));
    assign w_we = i_cmd.exec && w_is_load && w_load_ok;
    assign w_re = i_cmd.scan && (r_cnt < r_limit);

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDX_W'(r_eidx)),
        .i_wdata (SIZE_BITS'(r_esize)),
        .i_re    (w_re),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_fits = !r_busy[r_cmp_idx] && (CMP_W'(w_rdata) >= CMP_W'(r_rsize));
        case (r_policy)
            POL_BEST:  w_take = w_fits && (!r_found || (w_rdata < r_pick_size));
            POL_WORST: w_take = w_fits && (!r_found || (w_rdata > r_pick_size));
            default:   w_take = w_fits && !r_found;
        endcase
    end

    assign w_grant = w_is_alloc && r_found;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type  <= i_req_type;
            r_eidx  <= i_entry_index;
            r_esize <= i_entry_size;
            r_rsize <= i_request_size;
            r_tag   <= i_request_id;
        end
        if (r_cmp_vld && w_take) begin
            r_pick_idx  <= r_cmp_idx;
            r_pick_size <= w_rdata;
        end
        r_cmp_idx <= r_cnt[IDX_W-1:0];
        if (i_cmd.out_load) begin
            r_out_tag   <= r_tag;
            r_out_grant <= w_grant;
            // Widen before the increment so the last entry reports its full number
            r_out_pnum  <= w_grant ? (PNUM_W'(r_pick_idx) + PNUM_W'(1)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_FIRST;
            r_parts   <= PARTS_W'(MAX_ENTRIES);
            r_busy    <= '0;
            r_cnt     <= '0;
            r_limit   <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIT_POLICY:   r_policy <= i_cfg_wdata[POLICY_W-1:0];
                    CFG_PARTS_IN_USE: r_parts  <= i_cfg_wdata[PARTS_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.exec && w_is_load && w_load_ok) begin
                r_busy[IDX_W'(r_eidx)] <= 1'b0;
            end else if (i_cmd.exec && w_is_free) begin
                r_busy <= '0;
            end else if (i_cmd.commit && r_found) begin
                r_busy[r_pick_idx] <= 1'b1;
            end

            if (i_cmd.exec) begin
                r_cnt   <= '0;
                r_limit <= w_limit;
                r_found <= 1'b0;
            end else begin
                if (w_re) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_cmp_vld && w_take) begin
                    r_found <= 1'b1;
                end
            end
            r_cmp_vld <= w_re;

            // Hold the beat until taken
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.is_alloc  = w_is_alloc;
    assign o_stat.scan_done = (r_cnt == r_limit) && !r_cmp_vld;
    assign o_stat.out_free  = !r_out_vld || i_res_ready;

    assign o_res_valid        = r_out_vld;
    assign o_tag_echo         = r_out_tag;
    assign o_granted          = r_out_grant;
    assign o_partition_number = r_out_pnum;

    `FPFA_ASSERT_NEXT(a_commit_marks_busy, i_clk, i_rst_n, i_cmd.commit && r_found, r_busy[r_pick_idx])
    `FPFA_ASSERT_NOW(a_pick_in_range, i_clk, i_rst_n, r_found, CNT_W'(r_pick_idx) < r_limit)

endmodule

[rtl/fpfa_ctrl.sv]
`include "fixed_partition_fit_allocator_assert.svh"

module fpfa_ctrl import fpfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_EXEC;
            S_EXEC:   n_state = i_stat.is_alloc ? S_SCAN : S_DONE;
            S_SCAN:   if (i_stat.scan_done) n_state = S_COMMIT;
            S_COMMIT: n_state = S_DONE;
            S_DONE:   if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC:   o_cmd.exec = 1'b1;
            S_SCAN:   o_cmd.scan = 1'b1;
            S_COMMIT: o_cmd.commit = 1'b1;
            S_DONE:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    `FPFA_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, o_in_ready && i_in_valid, r_state == S_EXEC)
    `FPFA_ASSERT_NEXT(a_scan_to_commit, i_clk, i_rst_n, r_state == S_SCAN && i_stat.scan_done, r_state == S_COMMIT)

endmodule

[rtl/fixed_partition_fit_allocator.sv]
// Channel   Dir  Beat fields
// i_req     in   req_type, entry_index, entry_size, request_size, request_id
// o_res     out  tag_echo, granted, partition_number
// i_cfg_*   in   write enable, register index, write data (no read-back)
//
// Load, free-all and unknown requests skip the scan and go straight to the result beat.
// An allocation first scans the N searched entries (N up to 16), reading one
// size-table RAM entry per cycle; the allocator is ready for the next request
// in the cycle after the result beat is loaded into the output register.
// Reset (synchronous, active low) frees every partition; sizes are unknown until loaded.
// A stalled result beat holds in the output register; one more request is taken meanwhile.
module fixed_partition_fit_allocator import fpfa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fpfa_req_if.sink              i_req,
    fpfa_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_req.ready = w_in_ready;

    fpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fpfa_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_req_type         (i_req.req_type),
        .i_entry_index      (i_req.entry_index),
        .i_entry_size       (i_req.entry_size),
        .i_request_size     (i_req.request_size),
        .i_request_id       (i_req.request_id),
        .o_res_valid        (o_res.valid),
        .i_res_ready        (o_res.ready),
        .o_tag_echo         (o_res.tag_echo),
        .o_granted          (o_res.granted),
        .o_partition_number (o_res.partition_number)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import fpfa_pkg::*;

    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [POLICY_W-1:0]   POL_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]   kind;
        logic [ENTRY_IDX_W-1:0]  idx;
        logic [ENTRY_SIZE_W-1:0] esize;
        logic [REQ_SIZE_W-1:0]   rsize;
        logic [TAG_W-1:0]        tag;
    } alloc_req_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              granted;
        logic [PNUM_W-1:0] pnum;
    } alloc_res_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    fpfa_req_if req_if ();
    fpfa_res_if res_if ();

    fixed_partition_fit_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the allocator state
    logic [ENTRY_SIZE_W-1:0] part_size [MAX_ENTRIES];
    bit                      part_busy [MAX_ENTRIES];
    logic [POLICY_W-1:0]     cfg_policy = POL_FIRST;
    logic [PARTS_W-1:0]      cfg_parts = 5'd16;

    alloc_req_t pending_reqs [$];
    alloc_res_t grant_fifo [$];
    alloc_req_t bus_item = '0;
    bit         item_on_bus = 1'b0;
    bit         steady_tail = 1'b0;
    int         send_gap = 0;
    int         recv_stall = 0;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    function automatic alloc_res_t predict_allocation(alloc_req_t rq);
        alloc_res_t r;
        int limit;
        int pick;
        r.tag = rq.tag;
        r.granted = 1'b0;
        r.pnum = '0;
        case (rq.kind)
            REQ_LOAD: begin
                part_size[rq.idx] = rq.esize;
                part_busy[rq.idx] = 1'b0;
            end
            REQ_FREE_ALL: begin
                foreach (part_busy[i]) part_busy[i] = 1'b0;
            end
            REQ_ALLOC: begin
                limit = (cfg_parts > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_parts);
                pick = -1;
                for (int i = 0; i < limit; i++) begin
                    if (!part_busy[i] && part_size[i] >= rq.rsize) begin
                        if (cfg_policy == POL_BEST) begin
                            if (pick < 0 || part_size[i] < part_size[pick]) pick = i;
                        end else if (cfg_policy == POL_WORST) begin
                            if (pick < 0 || part_size[i] > part_size[pick]) pick = i;
                        end else if (pick < 0) begin
                            pick = i;
                        end
                    end
                end
                if (pick >= 0) begin
                    part_busy[pick] = 1'b1;
                    r.granted = 1'b1;
                    r.pnum = PNUM_W'(pick + 1);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic alloc_req_t mk_item(logic [REQ_TYPE_W-1:0] kind,
                                           logic [ENTRY_IDX_W-1:0] idx,
                                           logic [ENTRY_SIZE_W-1:0] esize,
                                           logic [REQ_SIZE_W-1:0] rsize,
                                           logic [TAG_W-1:0] tag);
        alloc_req_t rq;
        rq.kind = kind;
        rq.idx = idx;
        rq.esize = esize;
        rq.rsize = rsize;
        rq.tag = tag;
        return rq;
    endfunction

    // Few distinct sizes so ties and near misses are common
    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        if (r < 4) return 16'($urandom);
        return 16'($urandom_range(1, 8) * 64);
    endfunction

    function automatic alloc_req_t random_item();
        int r;
        logic [REQ_TYPE_W-1:0] kind;
        r = $urandom_range(0, 99);
        if (r < 58) kind = REQ_ALLOC;
        else if (r < 83) kind = REQ_LOAD;
        else if (r < 93) kind = REQ_FREE_ALL;
        else kind = REQ_UNKNOWN;
        return mk_item(kind, 4'($urandom_range(0, 15)), pick_size(), pick_size(),
                       8'($urandom_range(0, 255)));
    endfunction

    // Request side: hold a beat until taken, idle in short bursts
    always @(posedge i_clk) begin : req_driver
        logic drive_valid;
        drive_valid = req_if.valid;
        if (!i_rst_n) begin
            drive_valid = 1'b0;
            send_gap = 0;
            item_on_bus = 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                grant_fifo.push_back(predict_allocation(bus_item));
                item_on_bus = 1'b0;
                drive_valid = 1'b0;
            end
            if (!drive_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    if (!steady_tail && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(0, 2);
                    end else begin
                        bus_item = pending_reqs.pop_front();
                        item_on_bus = 1'b1;
                        drive_valid = 1'b1;
                    end
                end
            end
        end
        req_if.valid        <= drive_valid;
        req_if.req_type     <= bus_item.kind;
        req_if.entry_index  <= bus_item.idx;
        req_if.entry_size   <= bus_item.esize;
        req_if.request_size <= bus_item.rsize;
        req_if.request_id   <= bus_item.tag;
    end

    // Result side: check each beat against the oldest prediction
    always @(posedge i_clk) begin : res_monitor
        logic drive_ready;
        alloc_res_t want;
        drive_ready = 1'b0;
        if (!i_rst_n) begin
            recv_stall = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (grant_fifo.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: tag=%0h granted=%0b part=%0d",
                                 res_if.tag_echo, res_if.granted, res_if.partition_number);
                end else begin
                    want = grant_fifo.pop_front();
                    if (res_if.tag_echo !== want.tag || res_if.granted !== want.granted ||
                        res_if.partition_number !== want.pnum) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp tag=%0h granted=%0b part=%0d, got %0h %0b %0d",
                                     want.tag, want.granted, want.pnum, res_if.tag_echo,
                                     res_if.granted, res_if.partition_number);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
            end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
                recv_stall = $urandom_range(0, 2);
            end else begin
                drive_ready = 1'b1;
            end
        end
        res_if.ready <= drive_ready;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || item_on_bus || grant_fifo.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FIT_POLICY) cfg_policy = val[POLICY_W-1:0];
        else cfg_parts = val;
    endtask

    task automatic run_phase(logic [POLICY_W-1:0] policy, logic [PARTS_W-1:0] parts,
                             int count);
        alloc_req_t rq;
        int n;
        n = 0;
        wait_drained();
        write_reg(CFG_FIT_POLICY, CFG_DATA_W'(policy));
        write_reg(CFG_PARTS_IN_USE, parts);
        while (n < count) begin
            rq = random_item();
            pending_reqs.push_back(rq);
            if (rq.kind != REQ_UNKNOWN) n++;
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.req_type = '0;
        req_if.entry_index = '0;
        req_if.entry_size = '0;
        req_if.request_size = '0;
        req_if.request_id = '0;
        res_if.ready = 1'b0;
        foreach (part_busy[i]) begin
            part_busy[i] = 1'b0;
            part_size[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_FIT_POLICY, CFG_DATA_W'(POL_FIRST));
        write_reg(CFG_PARTS_IN_USE, 5'd16);

        // Load every entry before any scan can read it
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd0,  16'h0000, 16'h0000, 8'h00));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd1,  16'hFFFF, 16'hFFFF, 8'hFF));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd2,  16'd100,  16'h0000, 8'h02));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd3,  16'd40,   16'h0000, 8'h03));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd4,  16'd100,  16'h0000, 8'h04));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd5,  16'd40,   16'h0000, 8'h05));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd6,  16'd300,  16'h0000, 8'h06));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd7,  16'd300,  16'h0000, 8'h07));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd8,  16'd20,   16'h0000, 8'h08));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd9,  16'h8000, 16'h0000, 8'h09));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd10, 16'h7FFF, 16'h0000, 8'h0A));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd11, 16'd50,   16'h0000, 8'h0B));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd12, 16'd50,   16'h0000, 8'h0C));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd13, 16'h5555, 16'h0000, 8'h0D));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd14, 16'hAAAA, 16'h0000, 8'h0E));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd15, 16'd64,   16'h0000, 8'h0F));
        // Zero-size ask, largest ask, largest ask with nothing left that fits
        pending_reqs.push_back(mk_item(REQ_ALLOC, 4'd0, 16'h0000, 16'h0000, 8'h10));
        pending_reqs.push_back(mk_item(REQ_ALLOC, 4'd0, 16'h0000, 16'hFFFF, 8'h11));
        pending_reqs.push_back(mk_item(REQ_ALLOC, 4'd0, 16'h0000, 16'hFFFF, 8'h12));
        pending_reqs.push_back(mk_item(REQ_FREE_ALL, 4'hF, 16'hFFFF, 16'hFFFF, 8'h13));
        pending_reqs.push_back(mk_item(REQ_UNKNOWN, 4'hF, 16'hFFFF, 16'hFFFF, 8'h14));
        pending_reqs.push_back(mk_item(REQ_ALLOC, 4'd0, 16'h0000, 16'd41, 8'h15));
        pending_reqs.push_back(mk_item(REQ_LOAD, 4'd15, 16'h0000, 16'h0000, 8'hFF));
        pending_reqs.push_back(mk_item(REQ_ALLOC, 4'd0, 16'h0000, 16'h0000, 8'h16));

        run_phase(POL_FIRST,   5'd16, 140);
        run_phase(POL_BEST,    5'd16, 150);
        run_phase(POL_WORST,   5'd16, 150);
        run_phase(POL_UNKNOWN, 5'd16, 100);
        run_phase(POL_BEST,    5'd0,  60);
        run_phase(POL_WORST,   5'd31, 150);
        run_phase(POL_FIRST,   5'd1,  80);
        run_phase(POL_BEST,    5'd7,  150);
        run_phase(POL_WORST,   5'd3,  120);
        run_phase(POL_FIRST,   5'd20, 150);
        run_phase(POL_BEST,    5'd16, 150);
        steady_tail = 1'b1;
        run_phase(POL_WORST,   5'd12, 150);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && grant_fifo.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[fixed_partition_fit_allocator.f]
+incdir+rtl
rtl/fpfa_pkg.sv
rtl/fpfa_if.sv
rtl/fpfa_ram.sv
rtl/fpfa_datapath.sv
rtl/fpfa_ctrl.sv
rtl/fixed_partition_fit_allocator.sv
tb/tb_top.sv
